### hw/rtl/msmr_pkg.sv
package msmr_pkg;

  localparam int unsigned TicksPerStep    = 16;
  localparam int unsigned SubticksPerUnit = 1000;
  localparam int unsigned DelayUnit       = 100;

  localparam logic [1:0] OpCommand = 2'd0;
  localparam logic [1:0] OpRamp    = 2'd1;
  localparam logic [1:0] OpReverse = 2'd2;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhDecel = 2'd1;
  localparam logic [1:0] PhWait  = 2'd2;
  localparam logic [1:0] PhAccel = 2'd3;

  localparam logic [7:0] HoldTicks = 8'd255;

  localparam logic [2:0] RegStartSpeed   = 3'd0;
  localparam logic [2:0] RegAccelRate    = 3'd1;
  localparam logic [2:0] RegDecelRate    = 3'd2;
  localparam logic [2:0] RegSecAccelRate = 3'd3;
  localparam logic [2:0] RegSecBrakeRate = 3'd4;
  localparam logic [2:0] RegStartDelay   = 3'd5;
  localparam logic [2:0] RegAutoRevPer   = 3'd6;
  localparam logic [2:0] RegYardScale    = 3'd7;

  // Fields are listed from the highest bit down, so op sits in the lowest bits.
  typedef struct packed {
    logic [1:0] section_side;
    logic       swap_direction;
    logic       yard_mode;
    logic       emergency;
    logic [7:0] req_speed;
    logic [1:0] req_direction;
    logic [1:0] op;
  } item_t;

  typedef struct packed {
    logic [7:0] start_speed;
    logic [7:0] accel_rate;
    logic [7:0] decel_rate;
    logic [7:0] section_accel_rate;
    logic [7:0] section_brake_rate;
    logic [7:0] start_delay;
    logic [7:0] auto_reverse_period;
    logic [7:0] yard_scale;
  } cfg_t;

  // Fields are listed from the highest bit down, so pwm_speed sits lowest.
  typedef struct packed {
    logic       auto_reversed;
    logic [1:0] reversal_phase;
    logic [7:0] target_level;
    logic [7:0] current_speed;
    logic [1:0] pwm_direction;
    logic [7:0] pwm_speed;
  } result_t;

endpackage

### hw/rtl/msmr_regs.sv
module msmr_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output msmr_pkg::cfg_t    cfg_o
);
  import msmr_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            <= '0;
      cfg_q.yard_scale <= 8'd128;
    end else if (wr) begin
      case (idx)
        RegStartSpeed:   cfg_q.start_speed         <= pwdata[7:0];
        RegAccelRate:    cfg_q.accel_rate          <= pwdata[7:0];
        RegDecelRate:    cfg_q.decel_rate          <= pwdata[7:0];
        RegSecAccelRate: cfg_q.section_accel_rate  <= pwdata[7:0];
        RegSecBrakeRate: cfg_q.section_brake_rate  <= pwdata[7:0];
        RegStartDelay:   cfg_q.start_delay         <= pwdata[7:0];
        RegAutoRevPer:   cfg_q.auto_reverse_period <= pwdata[7:0];
        RegYardScale:    cfg_q.yard_scale          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegStartSpeed:   prdata[7:0] = cfg_q.start_speed;
      RegAccelRate:    prdata[7:0] = cfg_q.accel_rate;
      RegDecelRate:    prdata[7:0] = cfg_q.decel_rate;
      RegSecAccelRate: prdata[7:0] = cfg_q.section_accel_rate;
      RegSecBrakeRate: prdata[7:0] = cfg_q.section_brake_rate;
      RegStartDelay:   prdata[7:0] = cfg_q.start_delay;
      RegAutoRevPer:   prdata[7:0] = cfg_q.auto_reverse_period;
      RegYardScale:    prdata[7:0] = cfg_q.yard_scale;
      default:         prdata      = '0;
    endcase
  end

endmodule

### hw/rtl/msmr_core.sv
module msmr_core #(
  parameter int unsigned TICKS_PER_STEP    = msmr_pkg::TicksPerStep,
  parameter int unsigned SUBTICKS_PER_UNIT = msmr_pkg::SubticksPerUnit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  msmr_pkg::item_t   item_i,
  input  msmr_pkg::cfg_t    cfg_i,
  output msmr_pkg::result_t state_o
);
  import msmr_pkg::*;

  localparam logic [7:0] StepLim  = 8'(TICKS_PER_STEP);
  localparam logic [7:0] DelayLim = 8'(DelayUnit);
  localparam logic [9:0] SubLim   = 10'(SUBTICKS_PER_UNIT);

  logic [7:0] tgt_q, tgt_d, now_q, now_d, drv_q, drv_d;
  logic [1:0] dir_q, dir_d;
  logic [6:0] pre_q, pre_d;
  logic [7:0] rc_q, rc_d, cut_q, cut_d, dly_q, dly_d, dspd_q, dspd_d;
  logic       sw_q, sw_d;
  logic [1:0] ph_q, ph_d, pend_q, pend_d;
  logic       pvs_q, pvs_d;
  logic [7:0] swait_q, swait_d;
  logic [9:0] rsub_q, rsub_d;
  logic [7:0] rcnt_q, rcnt_d;
  logic       tog_q, tog_d;

  always_comb begin
    logic [15:0] prod;
    logic [7:0]  spd, rate;
    logic [1:0]  dir, side;
    logic        fall, cont, pres, hit;
    logic [7:0]  pn;
    logic [9:0]  sn;
    tgt_d = tgt_q; now_d = now_q; drv_d = drv_q; dir_d = dir_q; pre_d = pre_q;
    rc_d = rc_q; cut_d = cut_q; dly_d = dly_q; dspd_d = dspd_q; sw_d = sw_q;
    ph_d = ph_q; pend_d = pend_q; pvs_d = pvs_q; swait_d = swait_q;
    rsub_d = rsub_q; rcnt_d = rcnt_q; tog_d = tog_q;
    side = item_i.section_side;
    prod = item_i.req_speed * cfg_i.yard_scale;
    spd  = item_i.yard_mode ? prod[15:8] : item_i.req_speed;
    dir  = item_i.req_direction;
    if (item_i.swap_direction) dir = (dir == 2'd2) ? 2'd1 : 2'd2;
    rate = '0; fall = 1'b0; cont = 1'b1; pres = 1'b0; hit = 1'b0;
    pn = {1'b0, pre_q} + 8'd1;
    sn = rsub_q + 10'd1;
    case (item_i.op)
      OpCommand: begin
        if (item_i.emergency) begin
          ph_d = PhIdle; pvs_d = 1'b0; swait_d = '0; dly_d = '0; dspd_d = '0;
          cut_d = '0; now_d = '0; tgt_d = '0; pre_d = '0; rc_d = '0; drv_d = '0;
        end else begin
          pend_d = dir;
          if (ph_q != PhIdle) begin
            if ((ph_q == PhDecel || ph_q == PhWait) && dir == dir_q) begin
              if (pvs_q) sw_d = 1'b1;
              ph_d = PhIdle; pvs_d = 1'b0; swait_d = '0; pre_d = '0; rc_d = '0;
            end else begin
              tgt_d = spd;
              cont = 1'b0;
              if (ph_q == PhAccel && dir != dir_q) fall = 1'b1;
            end
          end
          if (cont && dir != dir_q && now_q != 0 && (dir_q == 2'd1 || dir_q == 2'd2)) begin
            tgt_d = spd; fall = 1'b1; cont = 1'b0;
            ph_d = PhDecel;
          end
          if (fall) begin
            ph_d = PhDecel; pvs_d = sw_d || side == dir_q;
            cut_d = '0; dly_d = '0; dspd_d = '0; pre_d = '0; rc_d = '0;
          end
          if (!cont) begin
            // Cap the speed while decelerating for a reversal.
            if (ph_d == PhDecel && spd < now_q) begin
              now_d = spd; drv_d = spd;
              if (spd == 0) begin
                ph_d = PhWait; swait_d = HoldTicks; pre_d = '0; rc_d = '0;
              end
            end
          end else begin
            if (dir != dir_q) begin
              dir_d = dir; cut_d = 8'd255;
            end
            if (tgt_q == 0 && cfg_i.start_delay != 0) begin
              if (spd != 0) begin
                if (dly_q == 0) begin
                  dly_d = cfg_i.start_delay; pre_d = '0;
                end
                dspd_d = spd; cont = 1'b0;
              end else begin
                dspd_d = '0;
              end
            end
            if (cont) begin
              tgt_d = spd;
              if (spd != 0 && spd < cfg_i.start_speed) spd = cfg_i.start_speed;
              if (spd != 0 && now_q < cfg_i.start_speed) now_d = cfg_i.start_speed;
              if (cut_d != 0) begin
                drv_d = '0;
              end else if (side != dir) begin
                if (!(sw_d && cfg_i.section_accel_rate != 0)) begin
                  sw_d = 1'b0;
                  if ((tgt_d < now_d && cfg_i.decel_rate == 0) ||
                      (tgt_d > now_d && cfg_i.accel_rate == 0) || tgt_d == now_d) begin
                    now_d = spd; drv_d = spd;
                  end
                end
              end else begin
                sw_d = 1'b1;
                if (cfg_i.section_brake_rate == 0 && cfg_i.decel_rate == 0) begin
                  now_d = '0; drv_d = '0;
                end
              end
            end
          end
        end
      end
      OpRamp: begin
        cont = 1'b1;
        if (ph_q == PhWait) begin
          cont = 1'b0; drv_d = '0; swait_d = swait_q - 8'd1;
          if (swait_d == 0) begin
            dir_d = pend_q; pre_d = '0; rc_d = '0;
            if (pvs_q) begin
              sw_d = 1'b1; ph_d = PhIdle;
            end else begin
              ph_d = PhAccel;
            end
          end
        end else if (ph_q != PhIdle) begin
          cont = 1'b0;
          if (ph_q == PhDecel) begin
            if (side == dir_q) pvs_d = 1'b1;
            rate = cfg_i.decel_rate;
          end else if (side == dir_q) begin
            ph_d = PhIdle; cont = 1'b1;
          end else begin
            rate = (now_q > tgt_q) ? cfg_i.decel_rate : cfg_i.accel_rate;
          end
          if (!cont) begin
            if (rate == 0) rate = 8'd1;
            if (pn >= StepLim) begin
              pre_d = '0;
              rc_d = rc_q + 8'd1;
              if (rc_d >= rate) begin
                rc_d = '0;
                if (ph_q == PhDecel) begin
                  if (now_q != 0) now_d = now_q - 8'd1;
                  drv_d = now_d;
                  if (now_d == 0) begin
                    ph_d = PhWait; swait_d = HoldTicks;
                  end
                end else begin
                  if (now_q < tgt_q) now_d = now_q + 8'd1;
                  else if (now_q > tgt_q) now_d = now_q - 8'd1;
                  drv_d = now_d;
                  if (now_d == tgt_q) ph_d = PhIdle;
                end
              end
            end else begin
              pre_d = pn[6:0];
            end
          end
        end
        if (cont) begin
          if (cut_q != 0) begin
            cut_d = cut_q - 8'd1;
            if (cut_d == 0 && ((tgt_q < now_q && cfg_i.decel_rate == 0) ||
                (tgt_q > now_q && cfg_i.accel_rate == 0) || tgt_q == now_q))
              drv_d = now_q;
          end else if (dly_q != 0) begin
            if (pn >= DelayLim) begin
              pre_d = '0; dly_d = dly_q - 8'd1;
              if (dly_d == 0) begin
                tgt_d = dspd_q; now_d = '0;
              end
            end else begin
              pre_d = pn[6:0];
            end
          end else if (pn < StepLim) begin
            pre_d = pn[6:0];
          end else begin
            pre_d = '0;
            rc_d = rc_q + 8'd1;
            if (side != dir_q) begin
              if (sw_q) begin
                if (cfg_i.section_accel_rate == 0) begin
                  if (cfg_i.accel_rate == 0) begin
                    now_d = tgt_q; drv_d = tgt_q; rc_d = '0;
                  end else if (rc_d >= cfg_i.accel_rate && now_q < tgt_q) pres = 1'b1;
                end else if (rc_d >= cfg_i.section_accel_rate && now_q < tgt_q) pres = 1'b1;
                if (pres) begin
                  now_d = now_q + 8'd1; drv_d = now_d; rc_d = '0;
                end
                if (now_d >= tgt_q) sw_d = 1'b0;
              end else if (now_q < tgt_q) begin
                if (rc_d >= cfg_i.accel_rate) begin
                  now_d = now_q + 8'd1; drv_d = now_d; rc_d = '0;
                end
              end else if (now_q > tgt_q) begin
                if (rc_d >= cfg_i.decel_rate) begin
                  now_d = now_q - 8'd1; drv_d = now_d; rc_d = '0;
                end
              end else begin
                rc_d = '0;
              end
            end else if (now_q != 0) begin
              sw_d = 1'b1;
              if (cfg_i.section_brake_rate == 0) begin
                if (cfg_i.decel_rate == 0) begin
                  now_d = '0; drv_d = '0; rc_d = '0;
                end else if (rc_d >= cfg_i.decel_rate) begin
                  now_d = now_q - 8'd1; drv_d = now_d; rc_d = '0;
                end
              end else if (rc_d >= cfg_i.section_brake_rate) begin
                now_d = now_q - 8'd1;
                if (tgt_q < now_d) now_d = tgt_q;
                drv_d = now_d; rc_d = '0;
              end
            end
          end
        end
      end
      OpReverse: begin
        if (ph_q == PhIdle && cfg_i.auto_reverse_period != 0) begin
          if (side != dir_q) begin
            rsub_d = '0; rcnt_d = '0;
          end else begin
            rsub_d = sn;
            hit = sn >= SubLim;
            if (hit) begin
              rsub_d = '0; rcnt_d = rcnt_q + 8'd1;
              if (rcnt_d >= cfg_i.auto_reverse_period) begin
                tog_d = ~tog_q;
                if (dir_q == 2'd1) dir_d = 2'd2;
                else if (dir_q == 2'd2) dir_d = 2'd1;
                cut_d = 8'd255; rcnt_d = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0; now_q <= '0; drv_q <= '0; dir_q <= 2'd3; pre_q <= '0;
      rc_q <= '0; cut_q <= '0; dly_q <= '0; dspd_q <= '0; sw_q <= 1'b0;
      ph_q <= PhIdle; pend_q <= '0; pvs_q <= 1'b0; swait_q <= '0;
      rsub_q <= '0; rcnt_q <= '0; tog_q <= 1'b0;
    end else if (step_i) begin
      tgt_q <= tgt_d; now_q <= now_d; drv_q <= drv_d; dir_q <= dir_d; pre_q <= pre_d;
      rc_q <= rc_d; cut_q <= cut_d; dly_q <= dly_d; dspd_q <= dspd_d; sw_q <= sw_d;
      ph_q <= ph_d; pend_q <= pend_d; pvs_q <= pvs_d; swait_q <= swait_d;
      rsub_q <= rsub_d; rcnt_q <= rcnt_d; tog_q <= tog_d;
    end
  end

  always_comb begin
    state_o.pwm_speed      = drv_q;
    state_o.pwm_direction  = dir_q;
    state_o.current_speed  = now_q;
    state_o.target_level   = tgt_q;
    state_o.reversal_phase = ph_q;
    state_o.auto_reversed  = tog_q;
  end

endmodule

### hw/rtl/motor_speed_momentum_reversal.sv
// Channel   Direction  Payload
// s_axis    in         op, req_direction, req_speed, emergency, yard_mode,
//                      swap_direction, section_side (17 bits in 24-bit tdata)
// m_axis    out        pwm_speed, pwm_direction, current_speed, target_level,
//                      reversal_phase, auto_reversed (29 bits in 32-bit tdata)
// apb       in/out     eight 8-bit registers at byte addresses 0 to 28
//
// Each accepted transaction updates the controller state registers, which
// drive the output directly; one item per cycle while m_axis is not stalled.
// The output is a single stage: input is taken whenever it is empty
// or its result is being taken in the same cycle.
// Reset is asynchronous and active low; it clears state and registers
// (yard_scale returns to 128, direction to unknown).
module motor_speed_momentum_reversal #(
  parameter int unsigned TICKS_PER_STEP    = msmr_pkg::TicksPerStep,
  parameter int unsigned SUBTICKS_PER_UNIT = msmr_pkg::SubticksPerUnit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] op, [3:2] req_direction, [11:4] req_speed, [12] emergency,
  // [13] yard_mode, [14] swap_direction, [16:15] section_side
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] pwm_speed, [9:8] pwm_direction, [17:10] current_speed,
  // [25:18] target_level, [27:26] reversal_phase, [28] auto_reversed
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msmr_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t st;
  logic    take;
  logic    vld_q;
  result_t res_q;

  assign item = item_t'(s_axis_tdata_i[16:0]);
  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign take = s_axis_tvalid_i && s_axis_tready_o;

  msmr_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  msmr_core #(
    .TICKS_PER_STEP(TICKS_PER_STEP),
    .SUBTICKS_PER_UNIT(SUBTICKS_PER_UNIT)
  ) u_core (
    .clk_i, .rst_ni, .step_i(take), .item_i(item), .cfg_i(cfg), .state_o(st)
  );

  // The core state is the result; it becomes visible in the cycle after the take.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= take;
    end
  end

  assign res_q = st;
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o = {3'b0, res_q.auto_reversed, res_q.reversal_phase,
                           res_q.target_level, res_q.current_speed,
                           res_q.pwm_direction, res_q.pwm_speed};

  // A stalled result must not change under the consumer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");
  // An accepted item always produces a result in the next cycle.
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> m_axis_tvalid_o)
    else $error("result missing");
  // While the reversal waits to turn, the motor is not driven.
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[27:26] == PhWait |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("speed driven while waiting to turn");

endmodule

### tb/msmr_checker.sv
module msmr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [23:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          errors_o,
  output int          pending_o
);
  import msmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] c_start, c_acc, c_dec, c_sacc, c_sbrk, c_delay, c_arp, c_yard;
  logic [7:0] tgt, now_s, drv, presc, rcnt, cut, dcnt, dspd, hold, rev_cnt;
  logic [1:0] dir, phase, pend;
  logic       sec_worked, via_sec, toggle;
  logic [9:0] rev_sub;
  result_t    motor_state_q[$];

  function automatic logic do_prescale(int unsigned limit);
    int unsigned n;
    n = presc + 1;
    if (n >= limit) begin
      presc = 0;
      return 1'b1;
    end
    presc = {1'b0, n[6:0]};
    return 1'b0;
  endfunction

  task automatic begin_reversal(logic [1:0] side);
    phase = PhDecel;
    via_sec = sec_worked || side == dir;
    cut = 0; dcnt = 0; dspd = 0; presc = 0; rcnt = 0;
  endtask

  task automatic cap_speed(logic [7:0] spd);
    if (phase != PhDecel || spd >= now_s) return;
    now_s = spd;
    drv = spd;
    if (spd == 0) begin
      phase = PhWait; hold = HoldTicks; presc = 0; rcnt = 0;
    end
  endtask

  function automatic logic rate_done();
    return (tgt < now_s && c_dec == 0) || (tgt > now_s && c_acc == 0) || tgt == now_s;
  endfunction

  task automatic apply_command(item_t it);
    logic [1:0] d;
    logic [7:0] spd;
    logic [15:0] prod;
    d = it.req_direction;
    spd = it.req_speed;
    if (it.emergency) begin
      phase = PhIdle; via_sec = 0; hold = 0; dcnt = 0; dspd = 0; cut = 0;
      now_s = 0; tgt = 0; presc = 0; rcnt = 0; drv = 0;
      return;
    end
    if (it.yard_mode) begin
      prod = spd * c_yard;
      spd = prod[15:8];
    end
    if (it.swap_direction) d = (d == 2'd2) ? 2'd1 : 2'd2;
    pend = d;
    if (phase != PhIdle) begin
      if ((phase == PhDecel || phase == PhWait) && d == dir) begin
        if (via_sec) sec_worked = 1;
        phase = PhIdle; via_sec = 0; hold = 0; presc = 0; rcnt = 0;
      end else begin
        tgt = spd;
        if (phase == PhAccel && d != dir) begin_reversal(it.section_side);
        cap_speed(spd);
        return;
      end
    end
    if (d != dir && now_s != 0 && (dir == 2'd1 || dir == 2'd2)) begin
      tgt = spd;
      begin_reversal(it.section_side);
      cap_speed(spd);
      return;
    end
    if (d != dir) begin
      dir = d;
      cut = 8'd255;
    end
    if (tgt == 0 && c_delay != 0) begin
      if (spd != 0) begin
        if (dcnt == 0) begin
          dcnt = c_delay; presc = 0;
        end
        dspd = spd;
        return;
      end
      dspd = 0;
    end
    tgt = spd;
    if (spd != 0 && spd < c_start) spd = c_start;
    if (spd != 0 && now_s < c_start) now_s = c_start;
    if (cut != 0) begin
      drv = 0;
      return;
    end
    if (it.section_side != d) begin
      if (sec_worked && c_sacc != 0) return;
      sec_worked = 0;
      if (rate_done()) begin
        now_s = spd; drv = spd;
      end
    end else begin
      sec_worked = 1;
      if (c_sbrk == 0 && c_dec == 0) begin
        now_s = 0; drv = 0;
      end
    end
  endtask

  // True while the reversal sequence owns speed and direction.
  function automatic logic reversal_step(logic [1:0] side);
    logic [7:0] rate;
    if (phase == PhIdle) return 1'b0;
    if (phase == PhWait) begin
      drv = 0;
      hold = hold - 1;
      if (hold != 0) return 1'b1;
      dir = pend; presc = 0; rcnt = 0;
      if (via_sec) begin
        sec_worked = 1; phase = PhIdle;
      end else begin
        phase = PhAccel;
      end
      return 1'b1;
    end
    if (phase == PhDecel) begin
      if (side == dir) via_sec = 1;
      rate = c_dec;
    end else begin
      if (side == dir) begin
        phase = PhIdle;
        return 1'b0;
      end
      rate = (now_s > tgt) ? c_dec : c_acc;
    end
    if (rate < 1) rate = 1;
    if (!do_prescale(TicksPerStep)) return 1'b1;
    rcnt = rcnt + 1;
    if (rcnt < rate) return 1'b1;
    rcnt = 0;
    if (phase == PhDecel) begin
      if (now_s != 0) now_s = now_s - 1;
      drv = now_s;
      if (now_s == 0) begin
        phase = PhWait; hold = HoldTicks;
      end
    end else begin
      if (now_s < tgt) now_s = now_s + 1;
      else if (now_s > tgt) now_s = now_s - 1;
      drv = now_s;
      if (now_s == tgt) phase = PhIdle;
    end
    return 1'b1;
  endfunction

  task automatic speed_up();
    now_s = now_s + 1; drv = now_s; rcnt = 0;
  endtask

  task automatic apply_ramp(logic [1:0] side);
    if (reversal_step(side)) return;
    if (cut != 0) begin
      cut = cut - 1;
      if (cut == 0 && rate_done()) drv = now_s;
      return;
    end
    if (dcnt != 0) begin
      if (do_prescale(DelayUnit)) begin
        dcnt = dcnt - 1;
        if (dcnt == 0) begin
          tgt = dspd; now_s = 0;
        end
      end
      return;
    end
    if (!do_prescale(TicksPerStep)) return;
    rcnt = rcnt + 1;
    if (side != dir) begin
      if (sec_worked) begin
        if (c_sacc == 0) begin
          if (c_acc == 0) begin
            now_s = tgt; drv = now_s; rcnt = 0;
          end else if (rcnt >= c_acc && now_s < tgt) speed_up();
        end else if (rcnt >= c_sacc && now_s < tgt) speed_up();
        if (now_s >= tgt) sec_worked = 0;
      end else if (now_s < tgt) begin
        if (rcnt >= c_acc) speed_up();
      end else if (now_s > tgt) begin
        if (rcnt >= c_dec) begin
          now_s = now_s - 1; drv = now_s; rcnt = 0;
        end
      end else begin
        rcnt = 0;
      end
    end else if (now_s != 0) begin
      sec_worked = 1;
      if (c_sbrk == 0) begin
        if (c_dec == 0) begin
          now_s = 0; drv = 0; rcnt = 0;
        end else if (rcnt >= c_dec) begin
          now_s = now_s - 1; drv = now_s; rcnt = 0;
        end
      end else if (rcnt >= c_sbrk) begin
        now_s = now_s - 1;
        if (tgt < now_s) now_s = tgt;
        drv = now_s; rcnt = 0;
      end
    end
  endtask

  task automatic apply_auto_reverse(logic [1:0] side);
    if (phase != PhIdle || c_arp == 0) return;
    if (side != dir) begin
      rev_sub = 0; rev_cnt = 0;
      return;
    end
    rev_sub = rev_sub + 1;
    if (rev_sub < SubticksPerUnit) return;
    rev_sub = 0;
    rev_cnt = rev_cnt + 1;
    if (rev_cnt >= c_arp) begin
      toggle = ~toggle;
      if (dir == 2'd1) dir = 2'd2;
      else if (dir == 2'd2) dir = 2'd1;
      cut = 8'd255; rev_sub = 0; rev_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t got, want;
    if (!rst_ni) begin
      c_start = 0; c_acc = 0; c_dec = 0; c_sacc = 0; c_sbrk = 0;
      c_delay = 0; c_arp = 0; c_yard = 8'd128;
      tgt = 0; now_s = 0; drv = 0; dir = 2'd3; presc = 0; rcnt = 0; cut = 0;
      dcnt = 0; dspd = 0; sec_worked = 0; phase = PhIdle; pend = 0; via_sec = 0;
      hold = 0; rev_sub = 0; rev_cnt = 0; toggle = 0;
      motor_state_q.delete();
      errors_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[28:0];
        if (motor_state_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors_o++;
        end else begin
          want = motor_state_q.pop_front();
          if (got.pwm_speed != want.pwm_speed)
            $display("%0t: pwm_speed expected %0d actual %0d", $time,
                     want.pwm_speed, got.pwm_speed);
          if (got.pwm_direction != want.pwm_direction)
            $display("%0t: pwm_direction expected %0d actual %0d", $time,
                     want.pwm_direction, got.pwm_direction);
          if (got.current_speed != want.current_speed)
            $display("%0t: current_speed expected %0d actual %0d", $time,
                     want.current_speed, got.current_speed);
          if (got.target_level != want.target_level)
            $display("%0t: target_level expected %0d actual %0d", $time,
                     want.target_level, got.target_level);
          if (got.reversal_phase != want.reversal_phase)
            $display("%0t: reversal_phase expected %0d actual %0d", $time,
                     want.reversal_phase, got.reversal_phase);
          if (got.auto_reversed != want.auto_reversed)
            $display("%0t: auto_reversed expected %0d actual %0d", $time,
                     want.auto_reversed, got.auto_reversed);
          if (got != want) errors_o++;
        end
      end
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i[4:2])
          RegStartSpeed:   c_start = pwdata_i[7:0];
          RegAccelRate:    c_acc   = pwdata_i[7:0];
          RegDecelRate:    c_dec   = pwdata_i[7:0];
          RegSecAccelRate: c_sacc  = pwdata_i[7:0];
          RegSecBrakeRate: c_sbrk  = pwdata_i[7:0];
          RegStartDelay:   c_delay = pwdata_i[7:0];
          RegAutoRevPer:   c_arp   = pwdata_i[7:0];
          default:         c_yard  = pwdata_i[7:0];
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        it.op = s_data_i[1:0];
        it.req_direction = s_data_i[3:2];
        it.req_speed = s_data_i[11:4];
        it.emergency = s_data_i[12];
        it.yard_mode = s_data_i[13];
        it.swap_direction = s_data_i[14];
        it.section_side = s_data_i[16:15];
        case (it.op)
          OpCommand: apply_command(it);
          OpRamp:    apply_ramp(it.section_side);
          OpReverse: apply_auto_reverse(it.section_side);
          default: ;
        endcase
        want.pwm_speed = drv;
        want.pwm_direction = dir;
        want.current_speed = now_s;
        want.target_level = tgt;
        want.reversal_phase = phase;
        want.auto_reversed = toggle;
        motor_state_q.push_back(want);
      end
    end
    pending_o = motor_state_q.size();
  end
endmodule

### tb/tb_motor_speed_momentum_reversal.sv
module tb_motor_speed_momentum_reversal;
  import msmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [1:0] op, [3:2] req_direction, [11:4] req_speed, [12] emergency,
  // [13] yard_mode, [14] swap_direction, [16:15] section_side
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] pwm_speed, [9:8] pwm_direction, [17:10] current_speed,
  // [25:18] target_level, [27:26] reversal_phase, [28] auto_reversed
  logic [31:0] m_axis_tdata_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending;
  int cycle_count = 0;
  // The receiver idles at random, except in the no-idle stretch and while it
  // holds off for a long pressure window.
  bit calm_mode = 1'b0;
  bit hold_off  = 1'b0;

  motor_speed_momentum_reversal uut (.*);

  msmr_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o), .s_data_i(s_axis_tdata_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_i(m_axis_tdata_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: the slowest correct run is far below this bound.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver drives tready at the falling edge.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (calm_mode) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(99) >= 38);
  end

  // Registers are written only while nothing is in flight.
  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0 || m_axis_tvalid_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_settings(logic [7:0] st, acc, dec, sacc, sbrk, dly, arp, yard);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    write_reg(RegStartSpeed, st);
    write_reg(RegAccelRate, acc);
    write_reg(RegDecelRate, dec);
    write_reg(RegSecAccelRate, sacc);
    write_reg(RegSecBrakeRate, sbrk);
    write_reg(RegStartDelay, dly);
    write_reg(RegAutoRevPer, arp);
    write_reg(RegYardScale, yard);
  endtask

  // Offer one transaction, with a random gap before it unless calm, and wait
  // until the block takes it. tvalid stays high into the next transaction
  // when there is no gap.
  task automatic send_item(logic [1:0] op, logic [1:0] d, logic [7:0] spd,
                           logic em, logic yard, logic swp, logic [1:0] side);
    if (!calm_mode && $urandom_range(99) < 38) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < 38) @(negedge clk_i);
    end
    s_axis_tdata_i <= {7'd0, side, swp, yard, em, spd, d, op};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [1:0] d, logic [7:0] spd, logic [1:0] side);
    send_item(OpCommand, d, spd, 1'b0, 1'b0, 1'b0, side);
  endtask

  task automatic send_ticks(int n, logic [1:0] side);
    repeat (n) send_item(OpRamp, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, side);
  endtask

  // Random traffic: mostly ramp ticks driving commanded motion, with some
  // reversals, section entries, auto-reverse ticks and noise.
  task automatic random_phase(int n);
    logic [1:0] dir_pick, side;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      dir_pick = 2'($urandom_range(1, 2));
      side = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd0;
      if (r < 15)
        send_item(OpCommand, ($urandom_range(9) == 0) ? 2'($urandom) : dir_pick,
                  8'($urandom), ($urandom_range(30) == 0), 1'($urandom),
                  ($urandom_range(5) == 0), side);
      else if (r < 80)
        send_item(OpRamp, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), side);
      else if (r < 97)
        send_item(OpReverse, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 2'($urandom));
      else
        send_item(2'd3, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: immediate rates, extremes of speed, direction codes and flags.
    load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_cmd(2'd1, 8'd255, 2'd0);
    send_ticks(3, 2'd0);
    send_item(OpCommand, 2'd1, 8'd200, 1'b0, 1'b1, 1'b0, 2'd0);
    send_item(OpCommand, 2'd0, 8'd100, 1'b0, 1'b0, 1'b1, 2'd0);
    send_item(OpCommand, 2'd3, 8'd0, 1'b0, 1'b0, 1'b0, 2'd3);
    send_item(OpCommand, 2'd2, 8'd255, 1'b1, 1'b1, 1'b1, 2'd3);
    send_item(2'd3, 2'd3, 8'd255, 1'b1, 1'b1, 1'b1, 2'd3);
    send_cmd(2'd1, 8'd50, 2'd1);
    send_ticks(2, 2'd1);
    send_item(OpReverse, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, 2'd1);

    // Operator reversal with the slowest-path rates floored at one.
    load_settings(8'd10, 8'd1, 8'd0, 8'd2, 8'd1, 8'd1, 8'd1, 8'd128);
    send_cmd(2'd1, 8'd3, 2'd0);
    send_cmd(2'd2, 8'd3, 2'd0);
    send_cmd(2'd1, 8'd3, 2'd0);

    // Pressure: the receiver stalls while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      send_ticks(8, 2'd0);
    join

    random_phase(300);
    load_settings(8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd128);
    calm_mode = 1'b1;
    random_phase(300);
    calm_mode = 1'b0;
    load_settings(8'($urandom), 8'($urandom_range(3)), 8'($urandom_range(3)),
                  8'($urandom_range(2)), 8'($urandom_range(2)), 8'($urandom_range(2)),
                  8'($urandom_range(1)), 8'($urandom));
    random_phase(350);
    load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    random_phase(300);
    load_settings(8'd5, 8'd0, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd200);
    random_phase(370);

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### motor_speed_momentum_reversal.f
hw/rtl/msmr_pkg.sv
hw/rtl/msmr_regs.sv
hw/rtl/msmr_core.sv
hw/rtl/motor_speed_momentum_reversal.sv
tb/msmr_checker.sv
tb/tb_motor_speed_momentum_reversal.sv
